// ----- src/acpd_pkg.sv -----
// acpd_pkg: shared types and constants for the arm command packet decoder
// sync byte, packet length, flag bit masks and the command codes
// no dependencies
package acpd_pkg;

	// framing
	localparam logic [7:0] SYNC_BYTE   = 8'h23;
	localparam int         PAYLOAD_LEN = 26;
	localparam int         IDX_W       = 5;
	localparam int         NUM_WORDS   = 6;

	// flag word bits, highest priority first
	localparam logic [15:0] FLAG_RESET = 16'h0080;
	localparam logic [15:0] FLAG_OPEN  = 16'h0010;
	localparam logic [15:0] FLAG_CLOSE = 16'h0008;
	localparam logic [15:0] FLAG_ONLY  = 16'h0004;
	localparam logic [15:0] FLAG_ABS   = 16'h0001;

	// result field widths
	localparam int CMD_W  = 3;
	localparam int FLAG_W = 16;
	localparam int DISP_W = 33;
	localparam int MAG_W  = 32;
	localparam int CNT_W  = 32;
	localparam int OUT_BITS = CMD_W + FLAG_W + 3 * DISP_W + MAG_W + CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// decoded command
	typedef enum logic [CMD_W-1:0] {
		CMD_RESET = 3'd0,
		CMD_OPEN  = 3'd1,
		CMD_CLOSE = 3'd2,
		CMD_FLAG  = 3'd3,
		CMD_ABS   = 3'd4,
		CMD_NONE  = 3'd5
	} cmd_t;

endpackage

// ----- src/arm_command_packet_decoder_top.sv -----
// arm_command_packet_decoder_top: byte stream parser and packet decoder
// parser registers, then displacement, magnitude and step count stages
// depends on acpd_pkg
//
// Takes one received byte per item on the slave stream and drops bytes until the
// sync byte '#' arrives. The next 26 bytes form a packet: a little-endian 16-bit
// flag word, then six little-endian signed 32-bit words (origin x, y, z, target
// x, y, z); a '#' inside a packet is plain data. One result item is produced per
// packet: the command decoded from the flag by priority (reset, open jaws, close
// jaws, flag only, absolute move, none), the raw flag, and for an absolute move
// the 33-bit displacements target minus origin and the step count (largest
// absolute displacement), else zeros, plus the running packet number. The block
// takes one byte every cycle while s_axis_tready is high. After the last byte of
// its packet, a result passes the three result stages (subtract, magnitude,
// maximum), the last of which is the output register. s_axis_tready drops only
// while all three result stages hold packets that the master side has not yet taken.
module arm_command_packet_decoder_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] rx_byte
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [2:0] command, [18:3] flag_word, [51:19] move_dx, [84:52] move_dy,
	// [117:85] move_dz, [149:118] step_count, [181:150] packet_count, rest zero
	output logic [acpd_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam int IW = acpd_pkg::IDX_W;
	localparam int DW = acpd_pkg::DISP_W;
	localparam int MW = acpd_pkg::MAG_W;
	localparam int CW = acpd_pkg::CNT_W;
	localparam int FW = acpd_pkg::FLAG_W;
	localparam int PAD_W = acpd_pkg::OUT_W - acpd_pkg::OUT_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(acpd_pkg::PAYLOAD_LEN - 1);

	// parser state
	logic           collecting_q;
	logic [IW-1:0]  byte_idx_q;
	logic [FW-1:0]  flag_q;
	logic [31:0]    field_q [acpd_pkg::NUM_WORDS];
	logic [CW-1:0]  pkt_cnt_q;

	// result stages
	logic                 v_s1, v_s2, v_s3;
	acpd_pkg::cmd_t       cmd_s1, cmd_s2, cmd_s3;
	logic [FW-1:0]        flag_s1, flag_s2, flag_s3;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [DW-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [DW-1:0] dx_s3, dy_s3, dz_s3;
	logic [MW-1:0]        mx_s2, my_s2, mz_s2;
	logic [MW-1:0]        step_s3;
	logic [CW-1:0]        cnt_s1, cnt_s2, cnt_s3;

	logic                 in_fire;
	logic                 pkt_done;
	logic                 move_s3, move_s2, move_s1;
	acpd_pkg::cmd_t       cmd_dec;
	logic [31:0]          tz_word;
	logic signed [DW-1:0] dx_c, dy_c, dz_c;
	logic [MW-1:0]        mx_c, my_c, mz_c;
	logic [MW-1:0]        step_c;

	// stall only when every result stage is full
	assign s_axis_tready = !(v_s1 && v_s2 && v_s3);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign pkt_done      = in_fire && collecting_q && (byte_idx_q == LAST_IDX);

	// stage moves, bubbles collapse
	assign move_s3 = !v_s3 || m_axis_tready;
	assign move_s2 = !v_s2 || move_s3;
	assign move_s1 = !v_s1 || move_s2;

	// sync hunt and byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			byte_idx_q   <= '0;
			pkt_cnt_q    <= '0;
		end else if (in_fire) begin
			if (!collecting_q) begin
				if (s_axis_tdata == acpd_pkg::SYNC_BYTE) begin
					collecting_q <= 1'b1;
					byte_idx_q   <= '0;
				end
			end else if (byte_idx_q == LAST_IDX) begin
				collecting_q <= 1'b0;
				byte_idx_q   <= '0;
				pkt_cnt_q    <= pkt_cnt_q + CW'(1);
			end else begin
				byte_idx_q <= byte_idx_q + IW'(1);
			end
		end
	end

	// payload byte capture into flag and word registers
	always_ff @(posedge clk) begin
		if (in_fire && collecting_q) begin
			if (byte_idx_q == IW'(0))
				flag_q[7:0] <= s_axis_tdata;
			if (byte_idx_q == IW'(1))
				flag_q[15:8] <= s_axis_tdata;
			for (int w = 0; w < acpd_pkg::NUM_WORDS; w++) begin
				for (int j = 0; j < 4; j++) begin
					if (byte_idx_q == IW'(2 + 4 * w + j))
						field_q[w][8*j +: 8] <= s_axis_tdata;
				end
			end
		end
	end

	// flag priority decode
	always_comb begin
		if ((flag_q & acpd_pkg::FLAG_RESET) != '0)
			cmd_dec = acpd_pkg::CMD_RESET;
		else if ((flag_q & acpd_pkg::FLAG_OPEN) != '0)
			cmd_dec = acpd_pkg::CMD_OPEN;
		else if ((flag_q & acpd_pkg::FLAG_CLOSE) != '0)
			cmd_dec = acpd_pkg::CMD_CLOSE;
		else if ((flag_q & acpd_pkg::FLAG_ONLY) != '0)
			cmd_dec = acpd_pkg::CMD_FLAG;
		else if ((flag_q & acpd_pkg::FLAG_ABS) != '0)
			cmd_dec = acpd_pkg::CMD_ABS;
		else
			cmd_dec = acpd_pkg::CMD_NONE;
	end

	// target z completes with the byte now arriving
	assign tz_word = {s_axis_tdata, field_q[5][23:0]};

	// displacements, sign-extended to 33 bits, zero unless absolute move
	always_comb begin
		if (cmd_dec == acpd_pkg::CMD_ABS) begin
			dx_c = $signed({field_q[3][31], field_q[3]}) - $signed({field_q[0][31], field_q[0]});
			dy_c = $signed({field_q[4][31], field_q[4]}) - $signed({field_q[1][31], field_q[1]});
			dz_c = $signed({tz_word[31], tz_word}) - $signed({field_q[2][31], field_q[2]});
		end else begin
			dx_c = '0;
			dy_c = '0;
			dz_c = '0;
		end
	end

	// stage 1: command, flag, displacements, packet number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (move_s1)
			v_s1 <= pkt_done;
	end

	always_ff @(posedge clk) begin
		if (move_s1 && pkt_done) begin
			cmd_s1  <= cmd_dec;
			flag_s1 <= flag_q;
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			dz_s1   <= dz_c;
			cnt_s1  <= pkt_cnt_q + CW'(1);
		end
	end

	// magnitudes fit in 32 bits since |d| < 2^32
	always_comb begin
		mx_c = dx_s1[DW-1] ? MW'(-dx_s1) : MW'(dx_s1);
		my_c = dy_s1[DW-1] ? MW'(-dy_s1) : MW'(dy_s1);
		mz_c = dz_s1[DW-1] ? MW'(-dz_s1) : MW'(dz_s1);
	end

	// stage 2: magnitudes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (move_s2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (move_s2 && v_s1) begin
			cmd_s2  <= cmd_s1;
			flag_s2 <= flag_s1;
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dz_s2   <= dz_s1;
			mx_s2   <= mx_c;
			my_s2   <= my_c;
			mz_s2   <= mz_c;
			cnt_s2  <= cnt_s1;
		end
	end

	// largest of three from parallel pairwise compares
	always_comb begin
		if (mx_s2 >= my_s2 && mx_s2 >= mz_s2)
			step_c = mx_s2;
		else if (my_s2 >= mz_s2)
			step_c = my_s2;
		else
			step_c = mz_s2;
	end

	// stage 3: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (move_s3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (move_s3 && v_s2) begin
			cmd_s3  <= cmd_s2;
			flag_s3 <= flag_s2;
			dx_s3   <= dx_s2;
			dy_s3   <= dy_s2;
			dz_s3   <= dz_s2;
			step_s3 <= step_c;
			cnt_s3  <= cnt_s2;
		end
	end

	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, cnt_s3, step_s3, dz_s3, dy_s3, dx_s3, flag_s3,
		cmd_s3};

`ifndef SYNTH
	// byte counter stays inside the packet
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_idx_q <= LAST_IDX)
		else $error("byte index beyond packet length");

	// hunting always restarts from the first payload byte
	a_idx_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		!collecting_q |-> byte_idx_q == '0)
		else $error("byte index nonzero while hunting");

	// a finished packet lands in stage 1 with the counted number
	a_pkt_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_done |=> v_s1 && cnt_s1 == pkt_cnt_q)
		else $error("completed packet not captured");

	// moves and steps only for an absolute move
	a_move_only_abs: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && cmd_s3 != acpd_pkg::CMD_ABS |-> step_s3 == '0 && dx_s3 == '0
			&& dy_s3 == '0 && dz_s3 == '0)
		else $error("displacement on a non-move command");

	// step count bounds every axis
	a_step_max: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && move_s3 |=> step_s3 >= $past(mx_s2) && step_s3 >= $past(my_s2)
			&& step_s3 >= $past(mz_s2))
		else $error("step count below an axis magnitude");
`endif

endmodule
